/* rtl/quadrature_dual_pid_controller_top_defines.svh */
// assertion macros for the controller checker
`ifndef QUADRATURE_DUAL_PID_CONTROLLER_TOP_DEFINES_SVH
`define QUADRATURE_DUAL_PID_CONTROLLER_TOP_DEFINES_SVH

// checked only out of reset
`define QDPID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define QDPID_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/qdpid_pkg.sv */
`timescale 1ns / 1ps
package qdpid_pkg;
	localparam int GAIN_W    = 20;
	localparam int TP_W      = 16;
	localparam int YAW_W     = 16;
	localparam int ERRA_W    = 12;
	localparam int ERRY_W    = 17;
	localparam int DIFA_W    = 13;
	localparam int DIV_W     = 18;
	localparam int ALT_ACC_W = 32;
	localparam int YAW_ACC_W = 48;
	localparam int MAC_W     = 72;
	localparam int DUTY_W    = 7;
	localparam int FRAC_W    = 16;
	localparam int MUL_W     = 25;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int P_W       = 21;
	localparam int STEP_W    = 4;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 5;

	localparam logic [2:0] REG_ALT_KP = 3'd0;
	localparam logic [2:0] REG_ALT_KI = 3'd1;
	localparam logic [2:0] REG_ALT_KD = 3'd2;
	localparam logic [2:0] REG_YAW_KP = 3'd3;
	localparam logic [2:0] REG_YAW_KI = 3'd4;
	localparam logic [2:0] REG_YAW_KD = 3'd5;
	localparam logic [2:0] REG_TICK   = 3'd6;

	localparam logic [GAIN_W-1:0] RST_ALT_KP = 20'd32768;
	localparam logic [GAIN_W-1:0] RST_ALT_KI = 20'd59;
	localparam logic [GAIN_W-1:0] RST_ALT_KD = 20'd52429;
	localparam logic [GAIN_W-1:0] RST_YAW_KP = 20'd39322;
	localparam logic [GAIN_W-1:0] RST_YAW_KI = 20'd590;
	localparam logic [GAIN_W-1:0] RST_YAW_KD = 20'd163840;
	localparam logic [TP_W-1:0]   RST_TICK   = 16'd20000;

	// multiply-accumulate sequence steps
	localparam logic [STEP_W-1:0] ST_ALT_BASE = 4'd0;
	localparam logic [STEP_W-1:0] ST_ALT_ILO  = 4'd1;
	localparam logic [STEP_W-1:0] ST_ALT_IHI  = 4'd2;
	localparam logic [STEP_W-1:0] ST_ALT_D    = 4'd3;
	localparam logic [STEP_W-1:0] ST_YAW_P    = 4'd4;
	localparam logic [STEP_W-1:0] ST_MAIN     = 4'd5;
	localparam logic [STEP_W-1:0] ST_YAW_INT  = 4'd6;
	localparam logic [STEP_W-1:0] ST_TAIL_BS  = 4'd7;
	localparam logic [STEP_W-1:0] ST_YAW_ILO  = 4'd8;
	localparam logic [STEP_W-1:0] ST_YAW_IHI  = 4'd9;
	localparam logic [STEP_W-1:0] ST_TAIL     = 4'd10;

	typedef struct packed {
		logic [GAIN_W-1:0] alt_kp;
		logic [GAIN_W-1:0] alt_ki;
		logic [GAIN_W-1:0] alt_kd;
		logic [GAIN_W-1:0] yaw_kp;
		logic [GAIN_W-1:0] yaw_ki;
		logic [GAIN_W-1:0] yaw_kd;
		logic [TP_W-1:0]   tick_period;
	} cfg_t;

	typedef struct packed {
		logic              capture;
		logic              enc;
		logic              err;
		logic              div_step;
		logic              der_a;
		logic              der_y;
		logic              mac;
		logic [STEP_W-1:0] step;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;
endpackage

/* rtl/qdpid_regs.sv */
`timescale 1ns / 1ps
module qdpid_regs import qdpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alt_kp      <= RST_ALT_KP;
			cfg_q.alt_ki      <= RST_ALT_KI;
			cfg_q.alt_kd      <= RST_ALT_KD;
			cfg_q.yaw_kp      <= RST_YAW_KP;
			cfg_q.yaw_ki      <= RST_YAW_KI;
			cfg_q.yaw_kd      <= RST_YAW_KD;
			cfg_q.tick_period <= RST_TICK;
		end else if (wr) begin
			case (idx)
				REG_ALT_KP: cfg_q.alt_kp      <= pwdata[GAIN_W-1:0];
				REG_ALT_KI: cfg_q.alt_ki      <= pwdata[GAIN_W-1:0];
				REG_ALT_KD: cfg_q.alt_kd      <= pwdata[GAIN_W-1:0];
				REG_YAW_KP: cfg_q.yaw_kp      <= pwdata[GAIN_W-1:0];
				REG_YAW_KI: cfg_q.yaw_ki      <= pwdata[GAIN_W-1:0];
				REG_YAW_KD: cfg_q.yaw_kd      <= pwdata[GAIN_W-1:0];
				REG_TICK:   cfg_q.tick_period <= pwdata[TP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ALT_KP: prdata = {12'd0, cfg_q.alt_kp};
			REG_ALT_KI: prdata = {12'd0, cfg_q.alt_ki};
			REG_ALT_KD: prdata = {12'd0, cfg_q.alt_kd};
			REG_YAW_KP: prdata = {12'd0, cfg_q.yaw_kp};
			REG_YAW_KI: prdata = {12'd0, cfg_q.yaw_ki};
			REG_YAW_KD: prdata = {12'd0, cfg_q.yaw_kd};
			REG_TICK:   prdata = {16'd0, cfg_q.tick_period};
			default:    prdata = 32'd0;
		endcase
	end
endmodule

/* rtl/qdpid_ctrl.sv */
`timescale 1ns / 1ps
module qdpid_ctrl import qdpid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  func,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [3:0] {
		IDLE, ENC, ERR, DIVA, DERA, DIVY, DERY, MAC, DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              accept;
	logic              load;

	assign in_ready  = (state_q == IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign load      = (state_q == DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept)
						state_q <= func ? ERR : ENC;
				end
				ENC:  state_q <= DONE;
				ERR:  state_q <= DIVA;
				DIVA: begin
					if (stat.div_done)
						state_q <= DERA;
				end
				DERA: state_q <= DIVY;
				DIVY: begin
					if (stat.div_done)
						state_q <= DERY;
				end
				DERY: begin
					state_q <= MAC;
					step_q  <= ST_ALT_BASE;
				end
				MAC: begin
					if (step_q == ST_TAIL)
						state_q <= DONE;
					else
						step_q <= step_q + 1'b1;
				end
				DONE: begin
					if (load)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.capture  = accept;
		cmd.enc      = (state_q == ENC);
		cmd.err      = (state_q == ERR);
		cmd.div_step = ((state_q == DIVA) || (state_q == DIVY)) && !stat.div_done;
		cmd.der_a    = (state_q == DERA);
		cmd.der_y    = (state_q == DERY);
		cmd.mac      = (state_q == MAC);
		cmd.step     = step_q;
		cmd.out_load = load;
	end
endmodule

/* rtl/qdpid_dp.sv */
`timescale 1ns / 1ps
module qdpid_dp import qdpid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	input  logic                     pin_a,
	input  logic                     pin_b,
	input  logic signed [7:0]        height_percent,
	input  logic signed [10:0]       target_height,
	input  logic signed [15:0]       target_yaw,
	output logic [DUTY_W-1:0]        main_drive,
	output logic [DUTY_W-1:0]        tail_drive,
	output logic signed [YAW_W-1:0]  yaw_position
);
	// captured request
	logic              pin_a_q, pin_b_q;
	logic signed [7:0]  hgt_q;
	logic signed [10:0] tgth_q;
	logic signed [15:0] tgty_q;

	// controller state
	logic [1:0]                    phase_q;
	logic [YAW_W-1:0]              yaw_q;
	logic signed [ERRA_W-1:0]      lasta_q;
	logic signed [ERRY_W-1:0]      lasty_q;
	logic signed [ALT_ACC_W-1:0]   alt_acc_q;
	logic signed [YAW_ACC_W-1:0]   yacc_q;
	logic [DUTY_W-1:0]             main_q, tail_q;

	// working registers
	logic signed [ERRA_W-1:0] ea_q;
	logic signed [ERRY_W-1:0] ey_q;
	logic signed [DIV_W-1:0]  diffy_q;
	logic [DIV_W-1:0]         dq_q;
	logic [TP_W-1:0]          rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic signed [DIFA_W-1:0] dera_q;
	logic signed [DIV_W-1:0]  dery_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MAC_W-1:0]  acc_q;
	logic signed [P_W-1:0]    p_q;

	logic [DUTY_W-1:0]       main_out_q, tail_out_q;
	logic [YAW_W-1:0]        yaw_out_q;

	logic [TP_W-1:0]          dt;
	logic signed [ERRA_W-1:0] ea;
	logic signed [ERRY_W-1:0] ey;
	logic signed [DIV_W-1:0]  diffa, diffy;
	logic signed [ALT_ACC_W:0] asum;
	logic signed [YAW_ACC_W:0] ysum;
	logic [1:0]               phase_now;
	logic [TP_W:0]            dv_t;
	logic                     dv_ge;
	logic signed [DIV_W-1:0]  qsigned;
	logic signed [MUL_W-1:0]  ma, mb;
	logic [16:0]              m45_prod;
	logic [DUTY_W-1:0]        m45;
	logic signed [MAC_W-1:0]  tail_base;
	logic signed [MAC_W-1:0]  trunc_acc;
	logic [DUTY_W-1:0]        duty_clamp;

	function automatic logic signed [MAC_W-1:0] trunc_frac(input logic signed [MAC_W-1:0] a);
		logic signed [MAC_W-1:0] q;
		q = a >>> FRAC_W;
		if (a[MAC_W-1] && (a[FRAC_W-1:0] != '0))
			q = q + 1'b1;
		return q;
	endfunction

	function automatic logic [DIV_W-1:0] mag(input logic signed [DIV_W-1:0] x);
		return x[DIV_W-1] ? DIV_W'(-x) : x;
	endfunction

	assign dt    = (cfg.tick_period == '0) ? TP_W'(1) : cfg.tick_period;
	assign ea    = ERRA_W'(tgth_q) - ERRA_W'(hgt_q);
	assign ey    = ERRY_W'(tgty_q) - ERRY_W'($signed(yaw_q));
	assign diffa = DIV_W'(ea) - DIV_W'(lasta_q);
	assign diffy = DIV_W'(ey) - DIV_W'(lasty_q);
	assign asum  = (ALT_ACC_W+1)'(alt_acc_q) + (ALT_ACC_W+1)'(ea);
	assign ysum  = (YAW_ACC_W+1)'(yacc_q) + (YAW_ACC_W+1)'($signed(prod_q[32:0]));
	assign phase_now = pin_a_q ? (pin_b_q ? 2'd2 : 2'd3) : (pin_b_q ? 2'd1 : 2'd0);

	// one restoring divide step
	assign dv_t    = {rem_q, dq_q[DIV_W-1]};
	assign dv_ge   = dv_t >= {1'b0, dt};
	assign qsigned = neg_q ? DIV_W'(-$signed(dq_q)) : $signed(dq_q);

	// main*40/50 as main*4*205 >> 10
	assign m45_prod  = 17'({main_q, 2'b00}) * 17'd205;
	assign m45       = m45_prod[16:10];
	assign tail_base = (MAC_W'($signed({1'b0, m45})) + MAC_W'(p_q)) <<< FRAC_W;
	assign trunc_acc  = trunc_frac(acc_q);

	always_comb begin
		if (trunc_acc < MAC_W'(2))
			duty_clamp = DUTY_W'(2);
		else if (trunc_acc > MAC_W'(98))
			duty_clamp = DUTY_W'(98);
		else
			duty_clamp = trunc_acc[DUTY_W-1:0];
	end

	always_comb begin
		case (cmd.step)
			ST_ALT_BASE: begin ma = MUL_W'({1'b0, cfg.alt_kp}); mb = MUL_W'(ea_q); end
			ST_ALT_ILO: begin
				ma = MUL_W'({1'b0, cfg.alt_ki});
				mb = MUL_W'({1'b0, alt_acc_q[15:0]});
			end
			ST_ALT_IHI: begin
				ma = MUL_W'({1'b0, cfg.alt_ki});
				mb = MUL_W'($signed(alt_acc_q[31:16]));
			end
			ST_ALT_D:   begin ma = MUL_W'({1'b0, cfg.alt_kd}); mb = MUL_W'(dera_q); end
			ST_YAW_P:   begin ma = MUL_W'({1'b0, cfg.yaw_kp}); mb = MUL_W'(ey_q); end
			ST_MAIN:    begin ma = MUL_W'(ey_q); mb = MUL_W'({1'b0, dt}); end
			ST_YAW_INT: begin ma = MUL_W'({1'b0, cfg.yaw_kd}); mb = MUL_W'(dery_q); end
			ST_TAIL_BS: begin
				ma = MUL_W'({1'b0, cfg.yaw_ki});
				mb = MUL_W'({1'b0, yacc_q[23:0]});
			end
			default: begin
				ma = MUL_W'({1'b0, cfg.yaw_ki});
				mb = MUL_W'($signed(yacc_q[47:24]));
			end
		endcase
	end

	assign stat.div_done = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			yaw_q     <= '0;
			lasta_q   <= '0;
			lasty_q   <= '0;
			alt_acc_q <= '0;
			yacc_q    <= '0;
			main_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.enc) begin
				phase_q <= phase_now;
				if (phase_now == phase_q + 2'd1)
					yaw_q <= yaw_q + 1'b1;
				else if (phase_now != phase_q)
					yaw_q <= yaw_q - 1'b1;
			end
			if (cmd.err) begin
				lasta_q <= ea;
				lasty_q <= ey;
				if (asum[ALT_ACC_W] != asum[ALT_ACC_W-1])
					alt_acc_q <= asum[ALT_ACC_W] ? {1'b1, {(ALT_ACC_W-1){1'b0}}}
						: {1'b0, {(ALT_ACC_W-1){1'b1}}};
				else
					alt_acc_q <= asum[ALT_ACC_W-1:0];
			end
			if (cmd.err || cmd.der_a)
				cnt_q <= CNT_W'(DIV_W);
			else if (cmd.div_step)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.mac && cmd.step == ST_MAIN)
				main_q <= duty_clamp;
			if (cmd.mac && cmd.step == ST_TAIL)
				tail_q <= duty_clamp;
			if (cmd.mac && cmd.step == ST_YAW_INT) begin
				if (ysum[YAW_ACC_W] != ysum[YAW_ACC_W-1])
					yacc_q <= ysum[YAW_ACC_W] ? {1'b1, {(YAW_ACC_W-1){1'b0}}}
						: {1'b0, {(YAW_ACC_W-1){1'b1}}};
				else
					yacc_q <= ysum[YAW_ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pin_a_q <= pin_a;
			pin_b_q <= pin_b;
			hgt_q   <= height_percent;
			tgth_q  <= target_height;
			tgty_q  <= target_yaw;
		end
		if (cmd.err) begin
			ea_q    <= ea;
			ey_q    <= ey;
			diffy_q <= diffy;
			dq_q    <= mag(diffa);
			neg_q   <= diffa[DIV_W-1];
			rem_q   <= '0;
		end else if (cmd.der_a) begin
			dera_q  <= DIFA_W'(qsigned);
			dq_q    <= mag(diffy_q);
			neg_q   <= diffy_q[DIV_W-1];
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= dv_ge ? TP_W'(dv_t - {1'b0, dt}) : dv_t[TP_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], dv_ge};
		end
		if (cmd.der_y)
			dery_q <= qsigned;
		if (cmd.mac) begin
			prod_q <= ma * mb;
			case (cmd.step)
				ST_ALT_BASE: acc_q <= MAC_W'(10) <<< FRAC_W;
				ST_ALT_ILO, ST_ALT_IHI, ST_YAW_P, ST_YAW_ILO: acc_q <= acc_q + MAC_W'(prod_q);
				ST_ALT_D:    acc_q <= acc_q + (MAC_W'(prod_q) <<< FRAC_W);
				ST_MAIN:     acc_q <= MAC_W'(prod_q);
				ST_YAW_INT:  p_q <= P_W'(trunc_acc);
				ST_TAIL_BS:  acc_q <= tail_base + MAC_W'(prod_q);
				ST_YAW_IHI:  acc_q <= acc_q + (MAC_W'(prod_q) <<< 24);
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			main_out_q <= main_q;
			tail_out_q <= tail_q;
			yaw_out_q  <= yaw_q;
		end
	end

	assign main_drive   = main_out_q;
	assign tail_drive   = tail_out_q;
	assign yaw_position = $signed(yaw_out_q);
endmodule

/* rtl/quadrature_dual_pid_controller_top.sv */
`timescale 1ns / 1ps
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// request   | in_valid / in_ready    | func, pin_a, pin_b, height_percent,
//           |                        | target_height, target_yaw
// result    | out_valid / out_ready  | main_drive, tail_drive, yaw_position
// config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// an encoder request runs ENC then DONE before the next acceptance; a control tick runs ERR,
// two 18-step serial divides for the derivatives (DIVA, DIVY), then 11 steps
// through one shared 25x25 multiplier with a 72-bit accumulator
// a new request is taken while the previous result waits in the output register,
// and the next result then holds until that one is taken
// arst_n clears all loop state; gains and tick period return to their defaults
module quadrature_dual_pid_controller_top import qdpid_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic                    pin_a,
	input  logic                    pin_b,
	input  logic signed [7:0]       height_percent,
	input  logic signed [10:0]      target_height,
	input  logic signed [15:0]      target_yaw,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DUTY_W-1:0]       main_drive,
	output logic [DUTY_W-1:0]       tail_drive,
	output logic signed [YAW_W-1:0] yaw_position,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	qdpid_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	qdpid_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .func, .out_valid, .out_ready, .stat, .cmd
	);

	qdpid_dp u_dp (
		.clk, .arst_n, .cfg, .cmd, .stat, .pin_a, .pin_b, .height_percent,
		.target_height, .target_yaw, .main_drive, .tail_drive, .yaw_position
	);
endmodule

/* rtl/qdpid_checker.sv */
`timescale 1ns / 1ps
`include "quadrature_dual_pid_controller_top_defines.svh"
module qdpid_checker import qdpid_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [DUTY_W-1:0]       main_drive,
	input logic [DUTY_W-1:0]       tail_drive,
	input logic signed [YAW_W-1:0] yaw_position
);
	`QDPID_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")
	`QDPID_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(main_drive) && $stable(tail_drive) && $stable(yaw_position), "stalled result changed")
	`QDPID_ASSERT(a_duty_range, out_valid |-> main_drive <= 7'd98 && tail_drive <= 7'd98 && (main_drive == 7'd0 || main_drive >= 7'd2) && (tail_drive == 7'd0 || tail_drive >= 7'd2), "duty out of range")
	`QDPID_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid && in_ready, "not idle in reset")
endmodule

bind quadrature_dual_pid_controller_top qdpid_checker u_qdpid_checker (.*);
